// ===== rtl/core/prqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types, sizes and helpers for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int NUM_LEVELS = 8;   // 1 .. 16
  localparam int NUM_TASKS  = 16;  // 2 .. 16

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int TASK_W = $clog2(NUM_TASKS);
  localparam int CNT_W  = $clog2(NUM_TASKS + 1);
  localparam int FIFO_DEPTH = NUM_LEVELS * NUM_TASKS;
  localparam int ADDR_W = $clog2(FIFO_DEPTH);

  localparam int IN_DATA_W  = 24;  // task_id, task_priority, current_sp
  localparam int OUT_DATA_W = 24;  // next_sp, next_task, status, pad

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [TASK_W-1:0] tid_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [0:0] {
    ACT_MAKE_READY = 1'b0,
    ACT_SCHEDULE   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OUT_RANGE = 2'd1,
    ST_LVL_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TASK = 2'd1,
    KIND_IDLE = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    FSM_IDLE = 5'b00001,
    FSM_EXEC = 5'b00010,
    FSM_SEL  = 5'b00100,
    FSM_PICK = 5'b01000,
    FSM_OUT  = 5'b10000
  } fsm_e;

  // Ring pointer advance with wrap at NUM_TASKS.
  function automatic tid_t ptr_inc(input tid_t ptr);
    tid_t res;
    if (32'(ptr) + 1 >= NUM_TASKS) begin
      res = '0;
    end else begin
      res = ptr + TASK_W'(1);
    end
    return res;
  endfunction

  // Queue store address: level major, slot minor.
  function automatic addr_t fifo_addr(input lvl_t lvl, input tid_t ptr);
    return ADDR_W'(lvl) * ADDR_W'(NUM_TASKS) + ADDR_W'(ptr);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Multilevel FIFO ready queues for a cooperative RTOS; level 0 served first.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                    Contents
// s_axis   in   s_axis_tvalid/s_axis_tready  make-ready or schedule request
// m_axis   out  m_axis_tvalid/m_axis_tready  chosen task, its stack pointer, status
//
// Make-ready runs through accept and update. Schedule runs through accept,
// save/requeue, queue store read, stack pointer read and output load when a
// task is picked, and through accept, save/requeue and output load when it
// falls back to idle; the queue store and the stack pointer memory both have
// registered reads. One transaction is in work at a time. A result waits in
// the output register; a new request is taken meanwhile and stalls only at
// its last step while the result is held.
// Reset empties all queues and marks every saved stack pointer as zero.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
  import prqs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // [3:0] task_id, [7:4] task_priority, [23:8] current_sp
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  wire logic                  s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [15:0] next_sp, [19:16] next_task, [21:20] status, [23:22] zero
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] next_is_idle
  output      logic                  m_axis_tuser
);

  // --- control state ---
  fsm_e  state_q, state_d;
  kind_e kind_q, kind_d;
  tid_t  cur_task_q, cur_task_d;
  logic  [15:0] idle_sp_q, idle_sp_d;

  // per-level ring pointers and fill counts
  tid_t head_q [NUM_LEVELS];
  tid_t head_d [NUM_LEVELS];
  tid_t tail_q [NUM_LEVELS];
  tid_t tail_d [NUM_LEVELS];
  cnt_t count_q [NUM_LEVELS];
  cnt_t count_d [NUM_LEVELS];

  // per-task bookkeeping
  lvl_t task_lvl_q [NUM_TASKS];
  lvl_t task_lvl_d [NUM_TASKS];
  logic [NUM_TASKS-1:0] running_q, running_d;
  logic [NUM_TASKS-1:0] sp_valid_q, sp_valid_d;

  // --- latched request (payload, no reset) ---
  action_e act_q;
  logic [3:0]  id_q;
  logic [3:0]  prio_q;
  logic [15:0] sp_q;
  status_e status_q, status_d;
  tid_t    pick_q, pick_d;

  // --- output register ---
  logic        m_valid_q, m_valid_d;
  logic        out_load;
  logic [15:0] out_sp_d, out_sp_q;
  logic [3:0]  out_task_d, out_task_q;
  logic        out_idle_d, out_idle_q;
  status_e     out_status_d, out_status_q;

  // --- memories ---
  tid_t        fifo_mem [FIFO_DEPTH];
  logic        fifo_we, fifo_re;
  addr_t       fifo_waddr, fifo_raddr;
  tid_t        fifo_wdata, fifo_rdata_q;

  logic [15:0] sp_mem [NUM_TASKS];
  logic        sp_we, sp_re;
  tid_t        sp_waddr, sp_raddr;
  logic [15:0] sp_wdata, sp_rdata_q;

  // --- decode helpers ---
  logic  in_accept;
  logic  out_free;
  logic  is_sched;
  logic  id_ok, prio_ok;
  tid_t  id_idx;
  lvl_t  prio_lvl;
  logic  push_req, push_full;
  lvl_t  push_lvl;
  tid_t  push_id;
  logic  sel_found;
  lvl_t  sel_lvl;

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign is_sched = (act_q == ACT_SCHEDULE);
  assign id_ok    = 32'(id_q) < NUM_TASKS;
  assign prio_ok  = 32'(prio_q) < NUM_LEVELS;
  assign id_idx   = TASK_W'(id_q);
  assign prio_lvl = LVL_W'(prio_q);

  // Push source: the new task on make-ready, the preempted task on schedule.
  always_comb begin
    if (is_sched) begin
      push_req = (kind_q == KIND_TASK) && running_q[cur_task_q];
      push_lvl = task_lvl_q[cur_task_q];
      push_id  = cur_task_q;
    end else begin
      push_req = id_ok && prio_ok;
      push_lvl = prio_lvl;
      push_id  = id_idx;
    end
  end
  assign push_full = (count_q[push_lvl] >= CNT_W'(NUM_TASKS));

  // First nonempty level, lowest index wins.
  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LVL_W'(l);
      end
    end
  end

  // Sequencer and state update.
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cur_task_d = cur_task_q;
    idle_sp_d  = idle_sp_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    task_lvl_d = task_lvl_q;
    running_d  = running_q;
    sp_valid_d = sp_valid_q;
    status_d   = status_q;
    pick_d     = pick_q;

    fifo_we    = 1'b0;
    fifo_waddr = fifo_addr(push_lvl, tail_q[push_lvl]);
    fifo_wdata = push_id;
    fifo_re    = 1'b0;
    fifo_raddr = fifo_addr(sel_lvl, head_q[sel_lvl]);
    sp_we      = 1'b0;
    sp_waddr   = cur_task_q;
    sp_wdata   = sp_q;
    sp_re      = 1'b0;
    sp_raddr   = fifo_rdata_q;

    out_load     = 1'b0;
    out_sp_d     = '0;
    out_task_d   = '0;
    out_idle_d   = 1'b0;
    out_status_d = ST_OK;

    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          state_d = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        if (!is_sched) begin
          // make-ready completes here, once the output register is free
          if (out_free) begin
            if (id_ok) begin
              running_d[id_idx] = 1'b0;
              if (prio_ok) begin
                task_lvl_d[id_idx] = prio_lvl;
              end
            end
            if (push_req && !push_full) begin
              fifo_we           = 1'b1;
              tail_d[push_lvl]  = ptr_inc(tail_q[push_lvl]);
              count_d[push_lvl] = count_q[push_lvl] + CNT_W'(1);
            end
            out_load = 1'b1;
            if (!id_ok || !prio_ok) begin
              out_status_d = ST_OUT_RANGE;
            end else if (push_full) begin
              out_status_d = ST_LVL_FULL;
            end
            state_d = FSM_IDLE;
          end
        end else begin
          // save stack pointer, requeue the running task
          status_d = ST_OK;
          if (kind_q == KIND_TASK) begin
            if (sp_q != '0) begin
              sp_we                  = 1'b1;
              sp_valid_d[cur_task_q] = 1'b1;
            end
            if (push_req) begin
              running_d[cur_task_q] = 1'b0;
              if (push_full) begin
                status_d = ST_LVL_FULL;
              end else begin
                fifo_we           = 1'b1;
                tail_d[push_lvl]  = ptr_inc(tail_q[push_lvl]);
                count_d[push_lvl] = count_q[push_lvl] + CNT_W'(1);
              end
            end
          end else if (kind_q == KIND_IDLE) begin
            if (sp_q != '0) begin
              idle_sp_d = sp_q;
            end
          end
          state_d = FSM_SEL;
        end
      end

      FSM_SEL: begin
        if (sel_found) begin
          fifo_re          = 1'b1;
          head_d[sel_lvl]  = ptr_inc(head_q[sel_lvl]);
          count_d[sel_lvl] = count_q[sel_lvl] - CNT_W'(1);
          state_d          = FSM_PICK;
        end else if (out_free) begin
          kind_d       = KIND_IDLE;
          cur_task_d   = '0;
          out_load     = 1'b1;
          out_sp_d     = idle_sp_q;
          out_idle_d   = 1'b1;
          out_status_d = status_q;
          state_d      = FSM_IDLE;
        end
      end

      FSM_PICK: begin
        // queue head is in fifo_rdata_q; fetch its saved stack pointer
        running_d[fifo_rdata_q] = 1'b1;
        cur_task_d = fifo_rdata_q;
        kind_d     = KIND_TASK;
        pick_d     = fifo_rdata_q;
        sp_re      = 1'b1;
        state_d    = FSM_OUT;
      end

      FSM_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_sp_d     = sp_valid_q[pick_q] ? sp_rdata_q : 16'd0;
          out_task_d   = 4'(pick_q);
          out_status_d = status_q;
          state_d      = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase

    m_valid_d = out_load ? 1'b1 : (m_valid_q && !m_axis_tready);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      kind_q     <= KIND_NONE;
      cur_task_q <= '0;
      idle_sp_q  <= '0;
      running_q  <= '0;
      sp_valid_q <= '0;
      m_valid_q  <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
        count_q[l] <= '0;
      end
      for (int t = 0; t < NUM_TASKS; t++) begin
        task_lvl_q[t] <= '0;
      end
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      cur_task_q <= cur_task_d;
      idle_sp_q  <= idle_sp_d;
      running_q  <= running_d;
      sp_valid_q <= sp_valid_d;
      m_valid_q  <= m_valid_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      task_lvl_q <= task_lvl_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q  <= action_e'(s_axis_tuser);
      id_q   <= s_axis_tdata[3:0];
      prio_q <= s_axis_tdata[7:4];
      sp_q   <= s_axis_tdata[23:8];
    end
    status_q <= status_d;
    pick_q   <= pick_d;
    if (out_load) begin
      out_sp_q     <= out_sp_d;
      out_task_q   <= out_task_d;
      out_idle_q   <= out_idle_d;
      out_status_q <= out_status_d;
    end
  end

  // Queue store: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (fifo_re) begin
      fifo_rdata_q <= fifo_mem[fifo_raddr];
    end
  end

  // Saved stack pointers; unwritten entries masked by sp_valid_q.
  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      sp_mem[sp_waddr] <= sp_wdata;
    end
    if (sp_re) begin
      sp_rdata_q <= sp_mem[sp_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_status_q, out_task_q, out_sp_q};
  assign m_axis_tuser  = out_idle_q;

endmodule
`default_nettype wire

// ===== sim/priority_ready_queue_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_tb
// Self-checking bench for the ready-queue scheduler. A scoreboard class keeps
// its own copy of the level queues, per-task stack pointers and the running
// task. It predicts one result per accepted request and checks the results
// in order. The stimulus opens with directed corners: idle fallback, idle
// stack pointer save, out-of-range priority, a full level and a dropped
// requeue. Random segments follow, each biased toward one hot level, with
// random stalls on both sides except in the last two segments.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_tb;
  import prqs_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
  localparam int NUM_SEGMENTS   = 14;
  localparam int SEGMENT_ITEMS  = 100;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic [15:0] sp;
    tid_t        tid;
    logic        idle;
    status_e     status;
  } sched_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: scheduler state and results still to come
  // --------------------------------------------------------------------------
  class ready_queue_scoreboard;
    tid_t        lvl_fifo  [NUM_LEVELS][NUM_TASKS];
    int          lvl_head  [NUM_LEVELS];
    int          lvl_tail  [NUM_LEVELS];
    int          lvl_count [NUM_LEVELS];
    logic [15:0] task_sp   [NUM_TASKS];
    lvl_t        task_lvl  [NUM_TASKS];
    bit          task_run  [NUM_TASKS];
    logic [15:0] idle_sp;
    tid_t        cur_task;
    kind_e       cur_kind;
    sched_result_t results_due[$];
    int          errors;

    function new();
      foreach (lvl_head[l]) begin
        lvl_head[l]  = 0;
        lvl_tail[l]  = 0;
        lvl_count[l] = 0;
      end
      foreach (task_sp[t]) begin
        task_sp[t]  = '0;
        task_lvl[t] = '0;
        task_run[t] = 1'b0;
      end
      idle_sp  = '0;
      cur_task = '0;
      cur_kind = KIND_NONE;
      errors   = 0;
    endfunction

    function bit level_append(int lvl, tid_t t);
      if (lvl >= NUM_LEVELS || lvl_count[lvl] >= NUM_TASKS) return 1'b0;
      lvl_fifo[lvl][lvl_tail[lvl]] = t;
      lvl_tail[lvl] = (lvl_tail[lvl] + 1 >= NUM_TASKS) ? 0 : lvl_tail[lvl] + 1;
      lvl_count[lvl]++;
      return 1'b1;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // Called once per accepted request transaction.
    function void note_request(action_e act, tid_t id, logic [3:0] prio,
                               logic [15:0] sp);
      sched_result_t res;
      tid_t          t;
      bit            found;
      res   = '{sp: '0, tid: '0, idle: 1'b0, status: ST_OK};
      found = 1'b0;
      t     = '0;
      if (act == ACT_MAKE_READY) begin
        if (int'(id) >= NUM_TASKS) begin
          res.status = ST_OUT_RANGE;
        end else begin
          task_run[id] = 1'b0;
          if (int'(prio) >= NUM_LEVELS) begin
            res.status = ST_OUT_RANGE;
          end else begin
            task_lvl[id] = lvl_t'(prio);
            if (!level_append(int'(prio), id)) res.status = ST_LVL_FULL;
          end
        end
        results_due.push_back(res);
        return;
      end
      // schedule: save the caller's sp, requeue it if still running
      if (cur_kind == KIND_TASK) begin
        if (sp != '0) task_sp[cur_task] = sp;
        if (task_run[cur_task]) begin
          task_run[cur_task] = 1'b0;
          if (!level_append(int'(task_lvl[cur_task]), cur_task)) res.status = ST_LVL_FULL;
        end
      end else if (cur_kind == KIND_IDLE) begin
        if (sp != '0) idle_sp = sp;
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (!found && lvl_count[l] > 0) begin
          t = lvl_fifo[l][lvl_head[l]];
          lvl_head[l] = (lvl_head[l] + 1 >= NUM_TASKS) ? 0 : lvl_head[l] + 1;
          lvl_count[l]--;
          found = 1'b1;
        end
      end
      if (found) begin
        task_run[t] = 1'b1;
        cur_task    = t;
        cur_kind    = KIND_TASK;
        res.sp      = task_sp[t];
        res.tid     = t;
      end else begin
        cur_task = '0;
        cur_kind = KIND_IDLE;
        res.sp   = idle_sp;
        res.idle = 1'b1;
      end
      results_due.push_back(res);
    endfunction

    // Called once per accepted result transaction.
    function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
      sched_result_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing pending: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (data[15:0] !== want.sp) begin
        $error("next_sp: expected %h, actual %h", want.sp, data[15:0]);
        errors++;
      end
      if (data[19:16] !== want.tid) begin
        $error("next_task: expected %0d, actual %0d", want.tid, data[19:16]);
        errors++;
      end
      if (data[21:20] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, data[21:20]);
        errors++;
      end
      if (data[23:22] !== 2'b00) begin
        $error("pad: expected 0, actual %b", data[23:22]);
        errors++;
      end
      if (user !== want.idle) begin
        $error("next_is_idle: expected %b, actual %b", want.idle, user);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [3:0] task_id, [7:4] task_priority, [23:8] current_sp
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // [0] action
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [15:0] next_sp, [19:16] next_task, [21:20] status, [23:22] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] next_is_idle
  logic                  m_axis_tuser;

  ready_queue_scoreboard sb;
  bit                    quiet_phase;   // no stalls on either side
  int                    stall_left;

  priority_ready_queue_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: ready held low in random bursts, none in the quiet phase.
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (!quiet_phase && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog: too long without any transaction on either side.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("priority_ready_queue_scheduler_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  task automatic issue_request(action_e act, tid_t id, logic [3:0] prio, logic [15:0] sp);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {sp, prio, id};
    s_axis_tuser  = act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(act, id, prio, sp);
    // random sender gap after the transaction
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_sp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'h0000;
    if (r < 25) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  // One random segment; most make-ready requests go to one hot level so
  // that it fills up when schedules are rare.
  task automatic run_random_segment(int sched_pct, int hot_lvl);
    int          r;
    logic [3:0]  prio;
    for (int i = 0; i < SEGMENT_ITEMS; i++) begin
      if ($urandom_range(0, 99) < sched_pct) begin
        issue_request(ACT_SCHEDULE, tid_t'($urandom_range(0, NUM_TASKS - 1)),
                      4'($urandom_range(0, 15)), random_sp());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75)      prio = 4'(hot_lvl);
        else if (r < 90) prio = 4'($urandom_range(0, NUM_LEVELS - 1));
        else             prio = 4'($urandom_range(NUM_LEVELS, 15));
        issue_request(ACT_MAKE_READY, tid_t'($urandom_range(0, NUM_TASKS - 1)), prio,
                      16'($urandom_range(0, 65535)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int sched_mix [4];
    sched_mix = '{10, 35, 50, 65};
    sb            = new();
    quiet_phase   = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing running: no save, idle fallback with zero sp
    issue_request(ACT_SCHEDULE, 4'd0, 4'd0, 16'h1234);
    // idle task running: its sp is saved, then kept when sp is zero
    issue_request(ACT_SCHEDULE, 4'd15, 4'd15, 16'hFFFF);
    issue_request(ACT_SCHEDULE, 4'd0, 4'd0, 16'h0000);
    // priority out of range
    issue_request(ACT_MAKE_READY, 4'd15, 4'd15, 16'hFFFF);
    issue_request(ACT_MAKE_READY, 4'd0, 4'(NUM_LEVELS), 16'h0000);
    // task 9 runs from the lowest-priority level
    issue_request(ACT_MAKE_READY, 4'd9, 4'(NUM_LEVELS - 1), 16'h0000);
    issue_request(ACT_SCHEDULE, 4'd0, 4'd0, 16'h0000);
    // fill that level (task 0 twice, a duplicate), then overflow it
    for (int i = 0; i < NUM_TASKS; i++) begin
      issue_request(ACT_MAKE_READY, (i == 9) ? 4'd0 : 4'(i), 4'(NUM_LEVELS - 1), 16'h5A5A);
    end
    issue_request(ACT_MAKE_READY, 4'd15, 4'(NUM_LEVELS - 1), 16'h0000);
    // requeue of task 9 hits the full level: dropped, status full
    issue_request(ACT_SCHEDULE, 4'd0, 4'd0, 16'hABCD);
    hold_until_drained();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg >= NUM_SEGMENTS - 2) quiet_phase = 1'b1;
      run_random_segment(sched_mix[$urandom_range(0, 3)], $urandom_range(0, NUM_LEVELS - 1));
      if (seg == NUM_SEGMENTS / 2) hold_until_drained();
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("priority_ready_queue_scheduler_tb: PASS");
    end else begin
      $display("priority_ready_queue_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/prqs_pkg.sv
rtl/core/priority_ready_queue_scheduler.sv
sim/priority_ready_queue_scheduler_tb.sv
